>>> hdl/error_detect_code_generator_unit_macros.svh
// Assertion helpers used by the checker file edc_checker.sv.
`ifndef ERROR_DETECT_CODE_GENERATOR_UNIT_MACROS_SVH
`define ERROR_DETECT_CODE_GENERATOR_UNIT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define EDC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define EDC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/edc_pkg.sv
package edc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned METHOD_W = 3;

    localparam logic [METHOD_W-1:0] METHOD_PARITY   = 3'd0;
    localparam logic [METHOD_W-1:0] METHOD_PARITY2D = 3'd1;
    localparam logic [METHOD_W-1:0] METHOD_CRC16    = 3'd2;
    localparam logic [METHOD_W-1:0] METHOD_HASH31   = 3'd3;
    localparam logic [METHOD_W-1:0] METHOD_CSUM     = 3'd4;

    localparam logic [VALUE_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [VALUE_W-1:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } t_edc_beat;

    // Reflected CRC-16 update for one byte, one shift per bit.
    function automatic logic [VALUE_W-1:0] crc16_byte(input logic [VALUE_W-1:0] crc,
                                                       input logic [BYTE_W-1:0]  b);
        logic [VALUE_W-1:0] c;
        c = crc ^ {{(VALUE_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> hdl/edc_stream_if.sv
interface edc_byte_if;
    logic                       valid;
    logic                       ready;
    logic [edc_pkg::BYTE_W-1:0] data_byte;
    logic                       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface edc_value_if;
    logic                        valid;
    logic                        ready;
    logic [edc_pkg::VALUE_W-1:0] control_value;

    modport source (output valid, output control_value, input ready);
    modport sink   (input valid, input control_value, output ready);
endinterface

>>> hdl/edc_accum.sv
module edc_accum (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  edc_pkg::t_edc_beat           i_beat,
    input  logic [edc_pkg::METHOD_W-1:0] i_method,
    output logic [edc_pkg::VALUE_W-1:0]  o_check
);

    logic                        r_parity, n_parity;
    logic [edc_pkg::BYTE_W-1:0]  r_col,    n_col;
    logic [edc_pkg::VALUE_W-1:0] r_crc,    n_crc;
    logic [edc_pkg::VALUE_W-1:0] r_hash,   n_hash;
    logic [edc_pkg::VALUE_W-1:0] r_sum,    n_sum;
    logic [edc_pkg::VALUE_W:0]   sum_wide;
    logic [edc_pkg::VALUE_W-1:0] byte_ext;

    assign byte_ext = {{(edc_pkg::VALUE_W-edc_pkg::BYTE_W){1'b0}}, i_beat.data_byte};

    always_comb begin
        n_parity = r_parity ^ (^i_beat.data_byte);
        n_col    = r_col ^ i_beat.data_byte;
        n_crc    = edc_pkg::crc16_byte(r_crc, i_beat.data_byte);
        // h * 31 is h * 32 - h.
        n_hash   = (r_hash << 5) - r_hash + byte_ext;
        sum_wide = {1'b0, r_sum} + {1'b0, byte_ext};
        // The carry folds back in; this cannot carry out again.
        n_sum    = sum_wide[edc_pkg::VALUE_W-1:0]
                   + {{(edc_pkg::VALUE_W-1){1'b0}}, sum_wide[edc_pkg::VALUE_W]};
    end

    always_comb begin
        unique case (i_method)
            edc_pkg::METHOD_PARITY:   o_check = {{(edc_pkg::VALUE_W-1){1'b0}}, n_parity};
            edc_pkg::METHOD_PARITY2D: o_check = {{(edc_pkg::VALUE_W-edc_pkg::BYTE_W-1){1'b0}},
                                                 n_parity, n_col};
            edc_pkg::METHOD_CRC16:    o_check = n_crc;
            edc_pkg::METHOD_HASH31:   o_check = n_hash;
            edc_pkg::METHOD_CSUM:     o_check = ~n_sum;
            default:                  o_check = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_beat.last)) begin
            r_parity <= 1'b0;
            r_col    <= '0;
            r_crc    <= edc_pkg::CRC_INIT;
            r_hash   <= '0;
            r_sum    <= '0;
        end else if (i_step) begin
            r_parity <= n_parity;
            r_col    <= n_col;
            r_crc    <= n_crc;
            r_hash   <= n_hash;
            r_sum    <= n_sum;
        end
    end

endmodule

>>> hdl/error_detect_code_generator_unit.sv
// Channel    Dir  Payload              Beat
// i_byte     in   data_byte[7:0], last one message byte
// o_value    out  control_value[15:0]  one check value per message
// i_cfg_*    in   method[2:0]          write when i_cfg_we is high
//
// One byte is taken every cycle while i_byte.ready is high; the check value
// appears in the output register in the cycle after the last byte is accepted.
// A byte is accepted while the output register is empty or being drained,
// so a stalled result holds off input only until it is taken.
// Synchronous reset clears the method to parity and restarts all sums.
module error_detect_code_generator_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [edc_pkg::METHOD_W-1:0] i_cfg_wdata,
    edc_byte_if.sink                     i_byte,
    edc_value_if.source                  o_value
);

    logic [edc_pkg::METHOD_W-1:0] r_method_code;
    logic                         r_out_valid;
    logic [edc_pkg::VALUE_W-1:0]  r_value;
    logic [edc_pkg::VALUE_W-1:0]  check;
    logic                         in_ready;
    logic                         step;
    edc_pkg::t_edc_beat           beat;

    assign in_ready = !r_out_valid || o_value.ready;
    assign step     = i_byte.valid && in_ready;
    assign beat     = '{data_byte: i_byte.data_byte, last: i_byte.last};

    assign i_byte.ready          = in_ready;
    assign o_value.valid         = r_out_valid;
    assign o_value.control_value = r_value;

    edc_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_beat   (beat),
        .i_method (r_method_code),
        .o_check  (check)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method_code <= edc_pkg::METHOD_PARITY;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_method_code <= i_cfg_wdata;
            end
            if (step) begin
                r_out_valid <= i_byte.last;
            end else if (o_value.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && i_byte.last) begin
            r_value <= check;
        end
    end

endmodule

>>> hdl/edc_checker.sv
`include "error_detect_code_generator_unit_macros.svh"

module edc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_in_last,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [edc_pkg::VALUE_W-1:0] i_out_value
);

    `EDC_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !i_out_valid, "result after reset")
    `EDC_ASSERT(a_stall_holds, i_clk, i_rst_n,
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value), "stalled result moved")
    `EDC_ASSERT(a_last_gives_result, i_clk, i_rst_n,
        i_in_valid && i_in_ready && i_in_last |=> i_out_valid, "last beat gave no result")
    `EDC_ASSERT(a_middle_no_result, i_clk, i_rst_n,
        i_in_valid && i_in_ready && !i_in_last && (!i_out_valid || i_out_ready) |=> !i_out_valid,
        "result without last beat")
    `EDC_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid |-> i_in_ready,
        "input held off with empty output")

endmodule

bind error_detect_code_generator_unit edc_checker u_edc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_byte.valid),
    .i_in_ready  (i_byte.ready),
    .i_in_last   (i_byte.last),
    .i_out_valid (o_value.valid),
    .i_out_ready (o_value.ready),
    .i_out_value (o_value.control_value)
);
